>>> sv/hidrd_pkg.sv
`default_nettype none

package hidrd_pkg;

   // usage counter saturation
   localparam int MAX_USAGES = 16;
   localparam int USAGE_CAP_INT = (MAX_USAGES < 31) ? MAX_USAGES : 31;
   localparam logic [4:0] USAGE_CAP = 5'(USAGE_CAP_INT);

   // prefix byte that opens a long item
   localparam logic [7:0] LONG_PREFIX = 8'hFE;

   // item types
   localparam logic [1:0] KIND_MAIN   = 2'd0;
   localparam logic [1:0] KIND_GLOBAL = 2'd1;
   localparam logic [1:0] KIND_LOCAL  = 2'd2;

   // main item tags
   localparam logic [3:0] TAG_INPUT    = 4'h8;
   localparam logic [3:0] TAG_OUTPUT   = 4'h9;
   localparam logic [3:0] TAG_COLL     = 4'hA;
   localparam logic [3:0] TAG_FEATURE  = 4'hB;
   localparam logic [3:0] TAG_END_COLL = 4'hC;

   // global item tags
   localparam logic [3:0] TAG_USAGE_PAGE = 4'h0;
   localparam logic [3:0] TAG_LOGICAL_MIN = 4'h1;
   localparam logic [3:0] TAG_LOGICAL_MAX = 4'h2;
   localparam logic [3:0] TAG_REPORT_SIZE = 4'h7;
   localparam logic [3:0] TAG_REPORT_ID = 4'h8;
   localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;

   // local item tags
   localparam logic [3:0] TAG_USAGE     = 4'h0;
   localparam logic [3:0] TAG_USAGE_MIN = 4'h1;
   localparam logic [3:0] TAG_USAGE_MAX = 4'h2;

   // report kinds
   localparam logic [1:0] RPT_INPUT   = 2'd0;
   localparam logic [1:0] RPT_OUTPUT  = 2'd1;
   localparam logic [1:0] RPT_FEATURE = 2'd2;

   // a complete short item, ready to act on
   typedef struct packed {
      logic        ready;
      logic [1:0]  kind;
      logic [3:0]  tag;
      logic [31:0] value;
   } item_type;

   // one report-format record
   typedef struct packed {
      logic [1:0]  report_type;
      logic [31:0] item_flags;
      logic [15:0] usage_page;
      logic [4:0]  usage_count;
      logic [31:0] usage_min;
      logic [31:0] usage_max;
      logic [31:0] logical_min;
      logic [31:0] logical_max;
      logic [15:0] report_size;
      logic [15:0] report_count;
      logic [7:0]  report_id;
      logic [7:0]  byte_offset;
   } result_type;

endpackage

`default_nettype wire

>>> sv/hidrd_item_decoder.sv
`default_nettype none

module hidrd_item_decoder (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire logic [7:0]          desc_byte,
   input  wire logic                last_byte,
   output hidrd_pkg::item_type      item
);
   import hidrd_pkg::*;

   logic [2:0]  size_ff, size_in;
   logic [1:0]  kind_ff, kind_in;
   logic [3:0]  tag_ff, tag_in;
   logic [2:0]  seen_ff, seen_in;
   logic [31:0] acc_ff, acc_in;

   logic [2:0]  prefix_size;
   logic [2:0]  seen_next;
   logic [31:0] acc_next;

   // size field: 3 means four bytes; the long-item prefix takes none
   always_comb begin
      if (desc_byte == LONG_PREFIX) begin
         prefix_size = 3'd0;
      end else if (desc_byte[1:0] == 2'd3) begin
         prefix_size = 3'd4;
      end else begin
         prefix_size = {1'b0, desc_byte[1:0]};
      end
   end

   // little-endian gather of data bytes
   assign seen_next = seen_ff + 3'd1;
   assign acc_next  = acc_ff | (32'(desc_byte) << {seen_ff[1:0], 3'b000});

   // item assembly and next state
   always_comb begin
      size_in = size_ff;
      kind_in = kind_ff;
      tag_in  = tag_ff;
      seen_in = seen_ff;
      acc_in  = acc_ff;
      if (size_ff == 3'd0) begin
         item.ready = (prefix_size == 3'd0) || last_byte;
         item.kind  = desc_byte[3:2];
         item.tag   = desc_byte[7:4];
         item.value = '0;
      end else begin
         item.ready = (seen_next >= size_ff) || last_byte;
         item.kind  = kind_ff;
         item.tag   = tag_ff;
         item.value = acc_next;
      end
      if (enable) begin
         if (item.ready) begin
            size_in = '0;
            kind_in = '0;
            tag_in  = '0;
            seen_in = '0;
            acc_in  = '0;
         end else if (size_ff == 3'd0) begin
            size_in = prefix_size;
            kind_in = desc_byte[3:2];
            tag_in  = desc_byte[7:4];
            seen_in = '0;
            acc_in  = '0;
         end else begin
            seen_in = seen_next;
            acc_in  = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         kind_ff <= '0;
         tag_ff  <= '0;
         seen_ff <= '0;
         acc_ff  <= '0;
      end else begin
         size_ff <= size_in;
         kind_ff <= kind_in;
         tag_ff  <= tag_in;
         seen_ff <= seen_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/hidrd_record_state.sv
`default_nettype none

module hidrd_record_state (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire logic                last_byte,
   input  wire hidrd_pkg::item_type item,
   output logic                     emit,
   output hidrd_pkg::result_type    result
);
   import hidrd_pkg::*;

   logic        in_coll_ff, in_coll_in;
   logic [15:0] global_page_ff, global_page_in;
   logic [15:0] page_ff, page_in;
   logic [31:0] umin_ff, umin_in;
   logic [31:0] umax_ff, umax_in;
   logic [31:0] lmin_ff, lmin_in;
   logic [31:0] lmax_ff, lmax_in;
   logic [15:0] rsize_ff, rsize_in;
   logic [15:0] rcount_ff, rcount_in;
   logic [7:0]  rid_ff, rid_in;
   logic [4:0]  ucount_ff, ucount_in;
   logic [10:0] in_off_ff, in_off_in;
   logic [10:0] oth_off_ff, oth_off_in;

   logic [15:0] page_eff;
   logic [10:0] grow;
   logic        is_input;
   logic [10:0] sel_off;

   // record page falls back to the global page when undefined
   assign page_eff = (page_ff == 16'd0) ? global_page_ff : page_ff;
   // only the low 11 bits of size times count reach the wrapped offset
   assign grow     = rsize_ff[10:0] * rcount_ff[10:0];
   assign is_input = (item.tag == TAG_INPUT);
   assign sel_off  = is_input ? in_off_ff : oth_off_ff;

   // record fields as seen by a main item
   always_comb begin
      if (is_input) begin
         result.report_type = RPT_INPUT;
      end else if (item.tag == TAG_OUTPUT) begin
         result.report_type = RPT_OUTPUT;
      end else begin
         result.report_type = RPT_FEATURE;
      end
      result.item_flags   = item.value;
      result.usage_page   = page_eff;
      result.usage_count  = ucount_ff;
      result.usage_min    = umin_ff;
      result.usage_max    = umax_ff;
      result.logical_min  = lmin_ff;
      result.logical_max  = lmax_ff;
      result.report_size  = rsize_ff;
      result.report_count = rcount_ff;
      result.report_id    = rid_ff;
      result.byte_offset  = sel_off[10:3];
   end

   // item handling
   always_comb begin
      in_coll_in     = in_coll_ff;
      global_page_in = global_page_ff;
      page_in        = page_ff;
      umin_in        = umin_ff;
      umax_in        = umax_ff;
      lmin_in        = lmin_ff;
      lmax_in        = lmax_ff;
      rsize_in       = rsize_ff;
      rcount_in      = rcount_ff;
      rid_in         = rid_ff;
      ucount_in      = ucount_ff;
      in_off_in      = in_off_ff;
      oth_off_in     = oth_off_ff;
      emit           = 1'b0;
      if (enable && item.ready) begin
         unique case (item.kind)
            KIND_MAIN: begin
               unique case (item.tag) inside
                  TAG_INPUT, TAG_OUTPUT, TAG_FEATURE: begin
                     emit    = 1'b1;
                     page_in = page_eff;
                     if (is_input) begin
                        in_off_in = in_off_ff + grow;
                     end else begin
                        oth_off_in = oth_off_ff + grow;
                     end
                  end
                  TAG_COLL: begin
                     in_coll_in = 1'b1;
                     page_in    = global_page_ff;
                     umin_in    = '0;
                     umax_in    = '0;
                     lmin_in    = '0;
                     lmax_in    = '0;
                     rsize_in   = '0;
                     rcount_in  = '0;
                     rid_in     = '0;
                     ucount_in  = 5'd1;
                  end
                  TAG_END_COLL: begin
                     in_coll_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            KIND_GLOBAL: begin
               unique case (item.tag)
                  TAG_USAGE_PAGE: begin
                     if (in_coll_ff) begin
                        page_in = item.value[15:0];
                     end else begin
                        global_page_in = item.value[15:0];
                     end
                  end
                  TAG_LOGICAL_MIN:  lmin_in   = item.value;
                  TAG_LOGICAL_MAX:  lmax_in   = item.value;
                  TAG_REPORT_SIZE:  rsize_in  = item.value[15:0];
                  TAG_REPORT_ID:    rid_in    = item.value[7:0];
                  TAG_REPORT_COUNT: rcount_in = item.value[15:0];
                  default: begin
                  end
               endcase
            end
            KIND_LOCAL: begin
               unique case (item.tag)
                  TAG_USAGE: begin
                     if (in_coll_ff && (ucount_ff < USAGE_CAP)) begin
                        ucount_in = ucount_ff + 5'd1;
                     end
                  end
                  TAG_USAGE_MIN: umin_in = item.value;
                  TAG_USAGE_MAX: umax_in = item.value;
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      // end of descriptor: everything back to its reset state
      if (enable && last_byte) begin
         in_coll_in     = 1'b0;
         global_page_in = '0;
         page_in        = '0;
         umin_in        = '0;
         umax_in        = '0;
         lmin_in        = '0;
         lmax_in        = '0;
         rsize_in       = '0;
         rcount_in      = '0;
         rid_in         = '0;
         ucount_in      = '0;
         in_off_in      = '0;
         oth_off_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_coll_ff     <= 1'b0;
         global_page_ff <= '0;
         page_ff        <= '0;
         umin_ff        <= '0;
         umax_ff        <= '0;
         lmin_ff        <= '0;
         lmax_ff        <= '0;
         rsize_ff       <= '0;
         rcount_ff      <= '0;
         rid_ff         <= '0;
         ucount_ff      <= '0;
         in_off_ff      <= '0;
         oth_off_ff     <= '0;
      end else begin
         in_coll_ff     <= in_coll_in;
         global_page_ff <= global_page_in;
         page_ff        <= page_in;
         umin_ff        <= umin_in;
         umax_ff        <= umax_in;
         lmin_ff        <= lmin_in;
         lmax_ff        <= lmax_in;
         rsize_ff       <= rsize_in;
         rcount_ff      <= rcount_in;
         rid_ff         <= rid_in;
         ucount_ff      <= ucount_in;
         in_off_ff      <= in_off_in;
         oth_off_ff     <= oth_off_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/hid_report_descriptor_parser_unit.sv
// Path: an accepted byte is held in the input register and decoded from there; a record
// that it completes is written to the result register, which drives rsp.
// Throughput: one byte per cycle; req_stall rises only while a byte is staged and the
// output register holds a record that rsp_stall is holding back.
// Reset: synchronous, active high; clears both valid flags and all parser state.
// A byte flagged last_byte also returns the parser to its reset state after use.
`default_nettype none

module hid_report_descriptor_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_desc_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_report_type,
   output logic [31:0]      rsp_item_flags,
   output logic [15:0]      rsp_usage_page,
   output logic [4:0]       rsp_usage_count,
   output logic [31:0]      rsp_usage_min,
   output logic [31:0]      rsp_usage_max,
   output logic [31:0]      rsp_logical_min,
   output logic [31:0]      rsp_logical_max,
   output logic [15:0]      rsp_report_size,
   output logic [15:0]      rsp_report_count,
   output logic [7:0]       rsp_report_id,
   output logic [7:0]       rsp_byte_offset
);
   import hidrd_pkg::*;

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic       advance;
   logic       accept;
   logic       emit;
   item_type   item;
   result_type result;

   // the staged item moves on whenever the output slot is free or being emptied
   assign advance   = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // input register
   always_comb begin
      byte_in = byte_ff;
      last_in = last_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
         byte_in        = req_desc_byte;
         last_in        = req_last_byte;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   hidrd_item_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .desc_byte (byte_ff),
      .last_byte (last_ff),
      .item      (item)
   );

   hidrd_record_state u_record (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .last_byte (last_ff),
      .item      (item),
      .emit      (emit),
      .result    (result)
   );

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_report_type  = rsp_ff.report_type;
   assign rsp_item_flags   = rsp_ff.item_flags;
   assign rsp_usage_page   = rsp_ff.usage_page;
   assign rsp_usage_count  = rsp_ff.usage_count;
   assign rsp_usage_min    = rsp_ff.usage_min;
   assign rsp_usage_max    = rsp_ff.usage_max;
   assign rsp_logical_min  = rsp_ff.logical_min;
   assign rsp_logical_max  = rsp_ff.logical_max;
   assign rsp_report_size  = rsp_ff.report_size;
   assign rsp_report_count = rsp_ff.report_count;
   assign rsp_report_id    = rsp_ff.report_id;
   assign rsp_byte_offset  = rsp_ff.byte_offset;

endmodule

`default_nettype wire

>>> sv/hidrd_checker.sv
`default_nettype none

module hidrd_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_stall,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_report_type,
   input  wire logic [4:0]  rsp_usage_count,
   input  wire logic [7:0]  rsp_byte_offset
);
   import hidrd_pkg::*;

   // a stalled item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result item dropped");

   // a stalled item keeps its byte offset and report type
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_byte_offset) && $stable(rsp_report_type))
      else $error("stalled result item changed");

   // only input, output and feature records come out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_report_type == RPT_INPUT) || (rsp_report_type == RPT_OUTPUT)
                    || (rsp_report_type == RPT_FEATURE))
      else $error("bad report type");

   // usage count never exceeds its cap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_usage_count <= USAGE_CAP)
      else $error("usage count beyond cap");

   // reset leaves both channels empty
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("channel busy after reset");

endmodule

bind hid_report_descriptor_parser_unit hidrd_checker u_hidrd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_report_type (rsp_report_type),
   .rsp_usage_count (rsp_usage_count),
   .rsp_byte_offset (rsp_byte_offset)
);

`default_nettype wire
